[hdl/bpip_pkg.sv]
// Shared types and constants for the banded point-in-polygon selector.
`timescale 1ns / 1ps
package bpip_pkg;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_BAND   = 2'd1,
    KIND_VERTEX = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // One classified beat handed from the front part to the back part.
  typedef struct packed {
    kind_t              kind;
    logic               cross_prev;
    logic               cross_close;
    logic               first_v;
    logic               ring_end;
    logic               poly_end;
    logic               ring_long;
    logic signed [15:0] bmin;
    logic signed [15:0] bmax;
  } cmd_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [31:0] dy;
    logic signed [32:0] ex;
    logic signed [31:0] ey;
    logic               straddle;
    logic               dpos;
  } edge_t;

endpackage

[hdl/bpip_front.sv]
// Front part: ring tracking and the two-stage edge crossing test for each vertex.
`timescale 1ns / 1ps
module bpip_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  bpip_pkg::kind_t     in_kind,
  input  logic signed [31:0]  in_lon,
  input  logic signed [30:0]  in_lat,
  input  logic signed [15:0]  in_band_min,
  input  logic signed [15:0]  in_band_max,
  input  logic                in_ring_last,
  input  logic                in_polygon_last,
  input  logic                stall,
  output logic                cmd_valid,
  output bpip_pkg::cmd_t      cmd
);

  logic signed [31:0] qlon_r, flon_r, plon_r;
  logic signed [30:0] qlat_r, flat_r, plat_r;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;

  // Stage one registers
  logic               s1_valid_r;
  bpip_pkg::cmd_t     s1_cmd_r;
  bpip_pkg::edge_t    e1_r, e2_r;

  bpip_pkg::edge_t    e1_nxt, e2_nxt;
  bpip_pkg::cmd_t     cmd_nxt;
  logic               is_v, rend;

  function automatic bpip_pkg::edge_t mk_edge(
    input logic signed [31:0] xi, input logic signed [30:0] yi,
    input logic signed [31:0] xj, input logic signed [30:0] yj,
    input logic signed [31:0] qx, input logic signed [30:0] qy);
    bpip_pkg::edge_t e;
    logic signed [31:0] d;
    e.straddle = (yi > qy) != (yj > qy);
    d          = 32'(yj) - 32'(yi);
    e.dpos     = d > 0;
    e.dy       = d;
    e.dx       = 33'(qx) - 33'(xi);
    e.ex       = 33'(xj) - 33'(xi);
    e.ey       = 32'(qy) - 32'(yi);
    return e;
  endfunction

  function automatic logic eval_edge(input bpip_pkg::edge_t e);
    logic signed [64:0] l, r;
    l = 65'(e.dx * e.dy);
    r = 65'(e.ex * e.ey);
    return e.straddle && (e.dpos ? (l < r) : (l > r));
  endfunction

  assign is_v = in_kind == bpip_pkg::KIND_VERTEX;
  assign rend = in_ring_last || in_polygon_last;
  assign e1_nxt = mk_edge(in_lon, in_lat, plon_r, plat_r, qlon_r, qlat_r);
  assign e2_nxt = mk_edge((cnt_r == 2'd0) ? in_lon : flon_r,
                          (cnt_r == 2'd0) ? in_lat : flat_r,
                          in_lon, in_lat, qlon_r, qlat_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && !stall) begin
      if (is_v) begin
        if (rend) cnt_nxt = 2'd0;
        else if (cnt_r != 2'd3) cnt_nxt = cnt_r + 2'd1;
      end else if (in_kind != bpip_pkg::KIND_VERTEX) begin
        cnt_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlon_r <= '0; qlat_r <= '0; flon_r <= '0; flat_r <= '0;
      plon_r <= '0; plat_r <= '0; cnt_r <= '0; s1_valid_r <= 1'b0;
    end else if (!stall) begin
      cnt_r      <= cnt_nxt;
      s1_valid_r <= in_valid;
      if (in_valid) begin
        if (in_kind == bpip_pkg::KIND_QUERY) begin
          qlon_r <= in_lon; qlat_r <= in_lat;
        end
        if (is_v) begin
          plon_r <= in_lon; plat_r <= in_lat;
          if (cnt_r == 2'd0) begin
            flon_r <= in_lon; flat_r <= in_lat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      e1_r                 <= e1_nxt;
      e2_r                 <= e2_nxt;
      s1_cmd_r.kind        <= in_kind;
      s1_cmd_r.cross_prev  <= 1'b0;
      s1_cmd_r.cross_close <= 1'b0;
      s1_cmd_r.first_v     <= cnt_r == 2'd0;
      s1_cmd_r.ring_end    <= rend;
      s1_cmd_r.poly_end    <= in_polygon_last;
      s1_cmd_r.ring_long   <= cnt_r >= 2'd2;
      s1_cmd_r.bmin        <= in_band_min;
      s1_cmd_r.bmax        <= in_band_max;
    end
  end

  // Stage two: the products, one pair per edge.
  always_comb begin
    cmd_nxt             = s1_cmd_r;
    cmd_nxt.cross_prev  = !s1_cmd_r.first_v && eval_edge(e1_r);
    cmd_nxt.cross_close = eval_edge(e2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid <= 1'b0;
    end else if (!stall) begin
      cmd_valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      cmd <= cmd_nxt;
    end
  end

endmodule

[hdl/bpip_queue.sv]
// Short queue of classified beats between the front and back parts.
`timescale 1ns / 1ps
module bpip_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  bpip_pkg::cmd_t wdata,
  input  logic           rd,
  output logic           nonempty,
  output logic           nearly_full,
  output bpip_pkg::cmd_t rdata
);

  bpip_pkg::cmd_t                 mem_r [bpip_pkg::QDEPTH];
  logic [bpip_pkg::QAW-1:0]       wp_r, rp_r;
  logic [bpip_pkg::QAW:0]         cnt_r;

  assign nonempty    = cnt_r != '0;
  // Two beats may still be in flight in the front pipeline.
  assign nearly_full = cnt_r >= (bpip_pkg::QAW+1)'(bpip_pkg::QDEPTH - 2);
  assign rdata       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (bpip_pkg::QAW+1)'(wr) - (bpip_pkg::QAW+1)'(rd);
    end
  end

endmodule

[hdl/bpip_back.sv]
// Back part: polygon and band bookkeeping, best band tracking and result register.
`timescale 1ns / 1ps
module bpip_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  bpip_pkg::cmd_t     cmd,
  output logic               cmd_take,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_found,
  output logic signed [15:0] out_result_min,
  output logic signed [15:0] out_result_max
);

  logic               par_r, outer_r, oin_r, hole_r, bm_r, bo_r, bf_r;
  logic signed [15:0] cmin_r, cmax_r, bmin_r, bmax_r;
  logic [16:0]        bs_r;
  logic               ov_r;

  logic               par, ring_in, oin, hole, match;
  logic signed [16:0] s;
  logic [16:0]        str;
  logic               better, nf;
  logic signed [15:0] nmin, nmax;
  logic [16:0]        nstr;

  assign out_empty = !ov_r;
  assign cmd_take  = cmd_valid && !(cmd.kind == bpip_pkg::KIND_END && ov_r && !out_pop);

  always_comb begin
    par     = (cmd.first_v ? 1'b0 : (par_r ^ cmd.cross_prev)) ^ cmd.cross_close;
    ring_in = cmd.ring_long && par;
    oin     = outer_r ? ring_in : oin_r;
    hole    = hole_r || (!outer_r && ring_in);
    match   = bm_r || (oin && !hole && bo_r);
    s       = 17'(cmin_r) + 17'(cmax_r);
    str     = s[16] ? 17'(-s) : 17'(s);
    better  = bo_r && bm_r && (!bf_r || str > bs_r);
    nf      = bf_r || better;
    nmin    = better ? cmin_r : bmin_r;
    nmax    = better ? cmax_r : bmax_r;
    nstr    = better ? str : bs_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r <= 1'b0; outer_r <= 1'b1; oin_r <= 1'b0; hole_r <= 1'b0;
      bm_r <= 1'b0; bo_r <= 1'b0; bf_r <= 1'b0; ov_r <= 1'b0;
      cmin_r <= '0; cmax_r <= '0; bmin_r <= '0; bmax_r <= '0; bs_r <= '0;
    end else begin
      if (out_pop && ov_r && !(cmd_take && cmd.kind == bpip_pkg::KIND_END)) ov_r <= 1'b0;
      if (cmd_take) begin
        unique case (cmd.kind) inside
          bpip_pkg::KIND_QUERY, bpip_pkg::KIND_END: begin
            if (cmd.kind == bpip_pkg::KIND_END) begin
              ov_r           <= 1'b1;
              out_found      <= nf;
              out_result_min <= nf ? nmin : 16'sd0;
              out_result_max <= nf ? nmax : 16'sd0;
            end
            bo_r <= 1'b0; bm_r <= 1'b0; bf_r <= 1'b0;
            bmin_r <= '0; bmax_r <= '0; bs_r <= '0;
            par_r <= 1'b0; outer_r <= 1'b1; oin_r <= 1'b0; hole_r <= 1'b0;
          end
          bpip_pkg::KIND_BAND: begin
            bf_r <= nf; bmin_r <= nmin; bmax_r <= nmax; bs_r <= nstr;
            cmin_r <= cmd.bmin; cmax_r <= cmd.bmax;
            bo_r <= 1'b1; bm_r <= 1'b0;
            par_r <= 1'b0; outer_r <= 1'b1; oin_r <= 1'b0; hole_r <= 1'b0;
          end
          default: begin
            par_r <= cmd.first_v ? 1'b0 : (par_r ^ cmd.cross_prev);
            if (cmd.ring_end) begin
              par_r   <= 1'b0;
              outer_r <= 1'b0;
              oin_r   <= oin;
              hole_r  <= hole;
              if (cmd.poly_end) begin
                bm_r <= match;
                outer_r <= 1'b1; oin_r <= 1'b0; hole_r <= 1'b0;
              end
            end
          end
        endcase
      end
    end
  end

endmodule

[hdl/band_point_in_polygon_select.sv]
// Top level of the banded point-in-polygon selector.
// A result is registered in the back part after its end-of-layer beat passes the
// front's stage-one and output registers and the queue. Throughput: one beat per
// cycle while in_full is low. The input reports full only once two beats wait in
// the four-entry queue, which happens only while a result waits unpopped.
// Reset is synchronous and active low; the query point reads as the origin after it.
`timescale 1ns / 1ps
module band_point_in_polygon_select (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_lon,
  input  logic signed [30:0] in_lat,
  input  logic signed [15:0] in_band_min,
  input  logic signed [15:0] in_band_max,
  input  logic               in_ring_last,
  input  logic               in_polygon_last,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_found,
  output logic signed [15:0] out_result_min,
  output logic signed [15:0] out_result_max
);

  // The front part computes both edge crossings of each vertex beat in a
  // two-stage pipeline; the queue absorbs beats while a result waits.
  logic           f_valid, q_ne, q_nf, take;
  bpip_pkg::cmd_t f_cmd, q_cmd;

  // The front never stalls; the beats in flight always fit the queue.
  assign in_full = q_nf;

  bpip_front u_front (
    .clk, .rst_n,
    .in_valid(in_push && !in_full),
    .in_kind(bpip_pkg::kind_t'(in_kind)),
    .in_lon, .in_lat, .in_band_min, .in_band_max, .in_ring_last, .in_polygon_last,
    .stall(1'b0),
    .cmd_valid(f_valid), .cmd(f_cmd)
  );

  bpip_queue u_queue (
    .clk, .rst_n, .wr(f_valid), .wdata(f_cmd), .rd(take),
    .nonempty(q_ne), .nearly_full(q_nf), .rdata(q_cmd)
  );

  bpip_back u_back (
    .clk, .rst_n, .cmd_valid(q_ne), .cmd(q_cmd), .cmd_take(take),
    .out_empty, .out_pop, .out_found, .out_result_min, .out_result_max
  );

  // A beat is never taken from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> q_ne) else $error("queue read while empty");

  // A waiting result holds until it is popped.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result_min)))
    else $error("result changed before pop");

  // A result that reports no band carries zero in both value fields.
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_found) |-> (out_result_min == 16'sd0 && out_result_max == 16'sd0))
    else $error("empty result carries data");

endmodule

[tb/band_point_in_polygon_select_checker.sv]
// Checker that predicts and compares the selector's result beats.
`timescale 1ns / 1ps
module band_point_in_polygon_select_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_lon,
  input  logic signed [30:0] in_lat,
  input  logic signed [15:0] in_band_min,
  input  logic signed [15:0] in_band_max,
  input  logic               in_ring_last,
  input  logic               in_polygon_last,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic               out_found,
  input  logic signed [15:0] out_result_min,
  input  logic signed [15:0] out_result_max,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic               found;
    logic signed [15:0] rmin;
    logic signed [15:0] rmax;
  } verdict_t;

  verdict_t verdicts[$];

  logic signed [31:0] q_lon, f_lon, p_lon;
  logic signed [30:0] q_lat, f_lat, p_lat;
  int unsigned        vcount;
  logic               parity, outer_ring, outer_in, hole_in, matched, open;
  logic signed [15:0] c_min, c_max, b_min, b_max;
  logic               b_found;
  logic [16:0]        b_strength;

  assign pending = verdicts.size();

  // True when the edge from (xj,yj) to (xi,yi) flips the ray parity.
  function automatic logic crosses(logic signed [31:0] xi, logic signed [30:0] yi,
                                   logic signed [31:0] xj, logic signed [30:0] yj);
    longint d, lhs, rhs;
    if ((yi > q_lat) == (yj > q_lat)) return 1'b0;
    d   = longint'(yj) - longint'(yi);
    lhs = (longint'(q_lon) - longint'(xi)) * d;
    rhs = (longint'(xj) - longint'(xi)) * (longint'(q_lat) - longint'(yi));
    return (d > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  task automatic clear_poly();
    vcount = 0; parity = 0; outer_ring = 1; outer_in = 0; hole_in = 0;
  endtask

  task automatic close_current_band();
    int s;
    logic [16:0] st;
    if (open && matched) begin
      s  = int'(c_min) + int'(c_max);
      st = 17'(s < 0 ? -s : s);
      if (!b_found || st > b_strength) begin
        b_found = 1; b_strength = st; b_min = c_min; b_max = c_max;
      end
    end
    open = 0; matched = 0;
  endtask

  task automatic take_beat();
    logic par, ring_in;
    verdict_t v;
    case (bpip_pkg::kind_t'(in_kind))
      bpip_pkg::KIND_QUERY: begin
        q_lon = in_lon; q_lat = in_lat;
        open = 0; matched = 0; b_found = 0; b_min = 0; b_max = 0; b_strength = 0;
        clear_poly();
      end
      bpip_pkg::KIND_BAND: begin
        close_current_band();
        c_min = in_band_min; c_max = in_band_max; open = 1; matched = 0;
        clear_poly();
      end
      bpip_pkg::KIND_VERTEX: begin
        if (vcount == 0) begin
          f_lon = in_lon; f_lat = in_lat; parity = 0;
        end else if (crosses(in_lon, in_lat, p_lon, p_lat)) begin
          parity = !parity;
        end
        p_lon = in_lon; p_lat = in_lat;
        if (vcount < 3) vcount++;
        if (in_ring_last || in_polygon_last) begin
          par = parity ^ crosses(f_lon, f_lat, in_lon, in_lat);
          ring_in = (vcount >= 3) && par;
          if (outer_ring) outer_in = ring_in;
          else if (ring_in) hole_in = 1;
          outer_ring = 0; vcount = 0; parity = 0;
          if (in_polygon_last) begin
            if (outer_in && !hole_in && open) matched = 1;
            clear_poly();
          end
        end
      end
      default: begin
        close_current_band();
        v.found = b_found;
        v.rmin  = b_found ? b_min : 16'sd0;
        v.rmax  = b_found ? b_max : 16'sd0;
        verdicts.push_back(v);
        b_found = 0; b_min = 0; b_max = 0; b_strength = 0;
        clear_poly();
      end
    endcase
  endtask

  always @(posedge clk) begin
    verdict_t w;
    if (!rst_n) begin
      q_lon = 0; q_lat = 0; f_lon = 0; f_lat = 0; p_lon = 0; p_lat = 0;
      clear_poly();
      matched = 0; open = 0; b_found = 0;
      c_min = 0; c_max = 0; b_min = 0; b_max = 0; b_strength = 0;
      verdicts.delete();
      fail_count = 0;
    end else begin
      if (!out_empty && out_pop) begin
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected result beat found=%0b min=%0d max=%0d",
                   $time, out_found, out_result_min, out_result_max);
          fail_count++;
        end else begin
          w = verdicts.pop_front();
          if (out_found !== w.found) begin
            $display("%0t: found expected %0b actual %0b", $time, w.found, out_found);
            fail_count++;
          end
          if (out_result_min !== w.rmin) begin
            $display("%0t: result_min expected %0d actual %0d", $time, w.rmin,
                     out_result_min);
            fail_count++;
          end
          if (out_result_max !== w.rmax) begin
            $display("%0t: result_max expected %0d actual %0d", $time, w.rmax,
                     out_result_max);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) take_beat();
    end
  end

endmodule

[tb/band_point_in_polygon_select_test.sv]
// Top of the selector testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module band_point_in_polygon_select_test;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_push = 0;
  logic               in_full;
  logic [1:0]         in_kind = bpip_pkg::KIND_QUERY;
  logic signed [31:0] in_lon = 0;
  logic signed [30:0] in_lat = 0;
  logic signed [15:0] in_band_min = 0;
  logic signed [15:0] in_band_max = 0;
  logic               in_ring_last = 0;
  logic               in_polygon_last = 0;
  logic               out_empty;
  logic               out_pop = 0;
  logic               out_found;
  logic signed [15:0] out_result_min, out_result_max;
  int                 fail_count, pending;
  int                 idle_cycles = 0;

  localparam int WATCHDOG = 5000;

  band_point_in_polygon_select uut (.*);

  band_point_in_polygon_select_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver pops at random; gaps are drawn in the same way as the sender's.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        out_pop <= 0;
        repeat (g) @(negedge clk);
      end
      out_pop <= 1;
    end
  end

  // Watchdog: counts cycles without any accepted beat on either channel.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("band_point_in_polygon_select_test: FAIL");
      $finish;
    end
  end

  // Drives one beat and holds it until the block accepts it. The push line is
  // left high so that back-to-back beats need no second assignment in a step.
  task automatic send(input bpip_pkg::kind_t k, input logic signed [31:0] lon,
                      input logic signed [30:0] lat, input logic signed [15:0] bmin,
                      input logic signed [15:0] bmax, input logic rl, input logic pl);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_push <= 0;
      repeat (g) @(negedge clk);
    end
    in_kind <= k; in_lon <= lon; in_lat <= lat; in_band_min <= bmin;
    in_band_max <= bmax; in_ring_last <= rl; in_polygon_last <= pl;
    in_push <= 1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic vertex(input logic signed [31:0] lon, input logic signed [30:0] lat,
                        input logic rl, input logic pl);
    send(bpip_pkg::KIND_VERTEX, lon, lat, 16'($urandom), 16'($urandom), rl, pl);
  endtask

  // Random coordinate pairs; some spread over the full bit range, most kept
  // near the query so that edges straddle it often.
  function automatic logic signed [31:0] rnd_lon(logic signed [31:0] c);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return c + $signed($urandom_range(0, 2000)) - 1000;
  endfunction

  function automatic logic signed [30:0] rnd_lat(logic signed [30:0] c);
    if ($urandom_range(0, 9) == 0) return 31'($urandom);
    return 31'(c + $signed($urandom_range(0, 2000)) - 1000);
  endfunction

  // One polygon: outer ring then up to two holes, each ring of random size.
  task automatic rnd_polygon(input logic signed [31:0] cl, input logic signed [30:0] ct,
                             inout int count);
    int rings, n;
    rings = $urandom_range(1, 3);
    for (int r = 0; r < rings; r++) begin
      n = $urandom_range(1, 7);
      for (int v = 0; v < n; v++) begin
        // Now and then polygon_last alone closes the ring.
        if (v == n - 1 && r == rings - 1)
          vertex(rnd_lon(cl), rnd_lat(ct), 1'($urandom_range(0, 1)), 1);
        else
          vertex(rnd_lon(cl), rnd_lat(ct), v == n - 1, 0);
        count++;
      end
    end
  endtask

  initial begin
    int count;
    logic signed [31:0] cl;
    logic signed [30:0] ct;
    count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: square around the origin with a hole, extremes, short ring,
    // vertices outside any band, empty layer, and ties between bands.
    send(bpip_pkg::KIND_END, 0, 0, 0, 0, 0, 0);
    vertex(-10, -10, 0, 0); vertex(10, -10, 0, 0); vertex(10, 10, 0, 0);
    vertex(-10, 10, 1, 1);
    send(bpip_pkg::KIND_BAND, 32'sh7fffffff, 31'sh3fffffff, 16'sh7fff, 16'sh7fff, 1, 1);
    vertex(-10, -10, 0, 0); vertex(10, -10, 0, 0); vertex(10, 10, 0, 0);
    vertex(-10, 10, 1, 0);
    vertex(-2, -2, 0, 0); vertex(2, -2, 0, 0); vertex(0, 2, 0, 1);
    send(bpip_pkg::KIND_BAND, 0, 0, -16'sd100, 16'sd100, 0, 0);
    vertex(32'sh80000000, 31'sh40000000, 0, 0);
    vertex(32'sh7fffffff, 31'sh40000000, 0, 0);
    vertex(32'sh7fffffff, 31'sh3fffffff, 0, 0);
    vertex(32'sh80000000, 31'sh3fffffff, 1, 1);
    send(bpip_pkg::KIND_BAND, 0, 0, -16'sd32768, -16'sd32768, 0, 0);
    vertex(-10, -10, 0, 0); vertex(10, 10, 1, 1);
    send(bpip_pkg::KIND_BAND, 0, 0, 16'sd5, -16'sd5, 0, 0);
    vertex(-10, -10, 0, 0); vertex(10, -10, 0, 0); vertex(0, 10, 0, 1);
    send(bpip_pkg::KIND_END, 0, 0, 0, 0, 0, 0);
    send(bpip_pkg::KIND_QUERY, 32'sh80000000, 31'sh40000000, 0, 0, 0, 0);
    send(bpip_pkg::KIND_END, 0, 0, 0, 0, 0, 0);

    // Sender pauses here until every expected result has come.
    in_push <= 0;
    while (pending != 0) @(negedge clk);

    while (count < 1050) begin
      cl = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 400)) - 200;
      ct = 31'($signed($urandom_range(0, 400)) - 200);
      send(bpip_pkg::KIND_QUERY, cl, ct, 16'($urandom), 16'($urandom),
           1'($urandom), 1'($urandom));
      count++;
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 7) == 0) begin
          vertex(rnd_lon(cl), rnd_lat(ct), 1'($urandom), 1'($urandom));
          count++;
        end
        send(bpip_pkg::KIND_BAND, $urandom, 31'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom), 1'($urandom));
        count++;
        repeat ($urandom_range(1, 3)) rnd_polygon(cl, ct, count);
      end
      send(bpip_pkg::KIND_END, $urandom, 31'($urandom), 16'($urandom), 16'($urandom),
           1'($urandom), 1'($urandom));
      count++;
    end
    in_push <= 0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("band_point_in_polygon_select_test: PASS");
    end else begin
      $display("band_point_in_polygon_select_test: FAIL");
    end
    $finish;
  end

endmodule
